// File: design/satm_pkg.sv
package satm_pkg;

  localparam int PIXEL_COUNT = 65536;
  localparam int MAX_SAMPLES = 4096;
  localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  localparam int IDX_W = 16;
  localparam int LIGHT_W = 24;
  localparam int SUM_W = 36;
  localparam int CNT_W = 13;
  localparam int BYTE_W = 8;
  localparam int LANES = 3;

  localparam int DIV_STEPS = 24;
  localparam int FRAC_STEPS = 32;
  localparam int SQRT_STEPS = 8;
  localparam int SQ_W = 2 * DIV_STEPS;
  localparam int ND_W = 62;
  localparam int THR_W = 16;
  localparam int PROD_W = 48;

  localparam int LANE_LAT = 2 + (DIV_STEPS + 1) + 2 + (FRAC_STEPS + 1) + (SQRT_STEPS + 1);

  localparam int NUM_SQ_K = 2259;
  localparam int NUM_LIN_K = 45 * 65536;
  localparam int DEN_SQ_K = 2187;
  localparam int DEN_LIN_K = 885 * 65536;
  localparam logic [ND_W-1:0] DEN_OFS = ND_W'(350) << 32;
  localparam int BYTE_SCALE = 65025;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 2'd1;
  localparam logic ACC_MODE_RESET = 1'b1;
  localparam logic [CNT_W-1:0] SAMPLE_LIMIT_RESET = 13'd64;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic [LIGHT_W-1:0] light;
    logic [CNT_W-1:0]  cnt;
  } lane_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              last;
  } result_t;

endpackage

// File: design/satm_lane.sv
module satm_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  satm_pkg::lane_in_t        lane_in,
  output logic [satm_pkg::BYTE_W-1:0] byte_out
);
  import satm_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]     rem;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_STEPS-1:0] quo;
    logic [CNT_W-1:0]     cnt;
    logic                 ovf;
  } div_t;

  typedef struct packed {
    logic [ND_W-1:0]       r;
    logic [ND_W-1:0]       den;
    logic [FRAC_STEPS-1:0] f;
    logic                  sat;
  } frac_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [BYTE_W-1:0] k;
    logic              sat;
  } root_t;

  logic [SUM_W-1:0]   sum_mem_r [PIXEL_COUNT];

  logic               a_vld_r;
  logic [ADDR_W-1:0]  a_addr_r;
  logic [LIGHT_W-1:0] a_light_r;
  logic [CNT_W-1:0]   a_cnt_r;
  logic [SUM_W-1:0]   a_rd_r;

  logic               b_vld_r;
  logic [ADDR_W-1:0]  b_addr_r;
  logic [SUM_W-1:0]   b_sum_r;
  logic [CNT_W-1:0]   b_cnt_r;

  logic [SUM_W-1:0]   base;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   b_sum_nxt;

  div_t               d_r   [DIV_STEPS+1];
  div_t               d_nxt [DIV_STEPS+1];
  logic [CNT_W:0]     div_trial [DIV_STEPS];
  logic               div_ge    [DIV_STEPS];

  logic [DIV_STEPS-1:0] avg;
  logic [DIV_STEPS-1:0] sq_a_r;
  logic [SQ_W-1:0]      sq_asq_r;
  logic [ND_W-1:0]      nd_num_r;
  logic [ND_W-1:0]      nd_den_r;

  frac_t              f_r   [FRAC_STEPS+1];
  frac_t              f_nxt [FRAC_STEPS+1];
  logic [ND_W-1:0]    frac_trial [FRAC_STEPS];
  logic               frac_ge    [FRAC_STEPS];

  logic [PROD_W-1:0]  prod;
  root_t              k_r   [SQRT_STEPS+1];
  root_t              k_nxt [SQRT_STEPS+1];
  logic [BYTE_W-1:0]  cand  [SQRT_STEPS];
  logic [THR_W-1:0]   cand_sq [SQRT_STEPS];

  // A sum written on the previous advance has not reached the read port yet.
  always_comb begin
    if (a_cnt_r == CNT_W'(1)) begin
      base = '0;
    end else if (b_vld_r && (b_addr_r == a_addr_r)) begin
      base = b_sum_r;
    end else begin
      base = a_rd_r;
    end
    sum_wide = {1'b0, base} + (SUM_W+1)'(a_light_r);
    b_sum_nxt = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rd_r <= sum_mem_r[lane_in.addr];
      if (a_vld_r) begin
        sum_mem_r[a_addr_r] <= b_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= lane_in.vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_comb begin
    d_nxt[0].ovf = {1'b0, b_sum_r} >= {b_cnt_r, {DIV_STEPS{1'b0}}};
    d_nxt[0].rem = d_nxt[0].ovf ? '0 : CNT_W'(b_sum_r[SUM_W-1:DIV_STEPS]);
    d_nxt[0].low = b_sum_r[DIV_STEPS-1:0];
    d_nxt[0].quo = '0;
    d_nxt[0].cnt = b_cnt_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      div_trial[i] = {d_r[i].rem, d_r[i].low[DIV_STEPS-1]};
      div_ge[i] = div_trial[i] >= {1'b0, d_r[i].cnt};
      d_nxt[i+1] = d_r[i];
      d_nxt[i+1].rem = div_ge[i] ? CNT_W'(div_trial[i] - {1'b0, d_r[i].cnt})
                                 : div_trial[i][CNT_W-1:0];
      d_nxt[i+1].low = {d_r[i].low[DIV_STEPS-2:0], 1'b0};
      d_nxt[i+1].quo = {d_r[i].quo[DIV_STEPS-2:0], div_ge[i]};
    end
  end

  assign avg = d_r[DIV_STEPS].ovf ? '1 : d_r[DIV_STEPS].quo;

  always_comb begin
    f_nxt[0].r = nd_num_r;
    f_nxt[0].den = nd_den_r;
    f_nxt[0].f = '0;
    f_nxt[0].sat = nd_num_r >= nd_den_r;
    for (int i = 0; i < FRAC_STEPS; i++) begin
      frac_trial[i] = {f_r[i].r[ND_W-2:0], 1'b0};
      frac_ge[i] = frac_trial[i] >= f_r[i].den;
      f_nxt[i+1] = f_r[i];
      f_nxt[i+1].r = frac_ge[i] ? (frac_trial[i] - f_r[i].den) : frac_trial[i];
      f_nxt[i+1].f = {f_r[i].f[FRAC_STEPS-2:0], frac_ge[i]};
    end
  end

  always_comb begin
    prod = PROD_W'(f_r[FRAC_STEPS].f) * PROD_W'(BYTE_SCALE);
    k_nxt[0].thr = prod[PROD_W-1:PROD_W-THR_W];
    k_nxt[0].k = '0;
    k_nxt[0].sat = f_r[FRAC_STEPS].sat;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      cand[i] = k_r[i].k | (BYTE_W'(1) << (SQRT_STEPS - 1 - i));
      cand_sq[i] = THR_W'(cand[i]) * THR_W'(cand[i]);
      k_nxt[i+1] = k_r[i];
      if (cand_sq[i] <= k_r[i].thr) begin
        k_nxt[i+1].k = cand[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_addr_r <= lane_in.addr;
      a_light_r <= lane_in.light;
      a_cnt_r <= lane_in.cnt;
      b_addr_r <= a_addr_r;
      b_sum_r <= b_sum_nxt;
      b_cnt_r <= a_cnt_r;
      d_r <= d_nxt;
      sq_a_r <= avg;
      sq_asq_r <= SQ_W'(avg) * SQ_W'(avg);
      nd_num_r <= ND_W'(NUM_SQ_K) * ND_W'(sq_asq_r) + ND_W'(NUM_LIN_K) * ND_W'(sq_a_r);
      nd_den_r <= ND_W'(DEN_SQ_K) * ND_W'(sq_asq_r) + ND_W'(DEN_LIN_K) * ND_W'(sq_a_r)
                  + DEN_OFS;
      f_r <= f_nxt;
      k_r <= k_nxt;
    end
  end

  assign byte_out = k_r[SQRT_STEPS].sat ? '1 : k_r[SQRT_STEPS].k;

endmodule

// File: design/satm_merge.sv
module satm_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_vld,
  input  satm_pkg::result_t   res,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output satm_pkg::result_t   out_word
);
  import satm_pkg::*;

  localparam logic [1:0] OCC_FULL = 2'd2;

  logic [1:0] occ_r;
  logic [1:0] occ_nxt;
  result_t    head_r;
  result_t    tail_r;
  logic       push;
  logic       pop;

  assign adv = (occ_r != OCC_FULL);
  assign push = adv && res_vld;
  assign out_valid = (occ_r != 2'd0);
  assign pop = out_valid && out_ready;
  assign out_word = head_r;
  assign occ_nxt = occ_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (occ_r == 2'd0) begin
          head_r <= res;
        end else begin
          tail_r <= res;
        end
      end
      2'b01: begin
        head_r <= tail_r;
      end
      2'b11: begin
        if (occ_r == 2'd1) begin
          head_r <= res;
        end else begin
          head_r <= tail_r;
          tail_r <= res;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == OCC_FULL && !pop |=> occ_r == OCC_FULL)
    else $error("output buffer lost a word");
`endif

endmodule

// File: design/sample_accumulate_tonemap_unit.sv
// Stages from input acceptance to out_valid: an input stage, 70 lane pipeline stages after it
// and one output buffer stage.
// Throughput: one pixel word per cycle while the output buffer is not full, allowed by the
// read-modify-write of the per-lane sum memory with forwarding of the word just written.
// Reset (rst_n, synchronous, active low): frame count 1, accumulate mode 1, sample limit 64,
// pipeline and output buffer emptied; the sum memory keeps its contents and is not cleared.
module sample_accumulate_tonemap_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [satm_pkg::IDX_W-1:0]         in_pixel_index,
  input  logic [satm_pkg::LIGHT_W-1:0]       in_light_red,
  input  logic [satm_pkg::LIGHT_W-1:0]       in_light_green,
  input  logic [satm_pkg::LIGHT_W-1:0]       in_light_blue,
  input  logic                               in_frame_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [satm_pkg::IDX_W-1:0]         out_index,
  output logic [satm_pkg::BYTE_W-1:0]        out_red,
  output logic [satm_pkg::BYTE_W-1:0]        out_green,
  output logic [satm_pkg::BYTE_W-1:0]        out_blue,
  output logic                               out_last_pixel,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [satm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [satm_pkg::CNT_W-1:0]         cfg_data
);
  import satm_pkg::*;

  logic              adv;
  logic              acc;
  logic              acc_mode_r;
  logic [CNT_W-1:0]  sample_limit_r;
  logic [CNT_W-1:0]  fc_r;
  logic [CNT_W-1:0]  fc_nxt;
  logic [CNT_W-1:0]  limit_eff;
  logic [CNT_W-1:0]  cnt_use;
  logic              drop;
  logic              in_range;
  logic              emit;

  logic [LIGHT_W-1:0] light [LANES];
  lane_in_t           lane_in [LANES];
  logic [BYTE_W-1:0]  lane_byte [LANES];

  logic               meta_vld_r  [LANE_LAT];
  logic [IDX_W-1:0]   meta_idx_r  [LANE_LAT];
  logic               meta_last_r [LANE_LAT];

  result_t            res;
  result_t            out_word;

  assign in_ready = adv;
  assign cfg_ready = 1'b1;
  assign acc = in_valid && in_ready;

  assign limit_eff = (32'(sample_limit_r) > 32'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                              : sample_limit_r;
  assign drop = acc_mode_r && (fc_r >= limit_eff);
  assign in_range = ({16'b0, in_pixel_index} < 32'(PIXEL_COUNT));
  assign emit = acc && !in_mode && !drop && in_range;

  always_comb begin
    cnt_use = acc_mode_r ? fc_r : CNT_W'(1);
    if (cnt_use == '0) begin
      cnt_use = CNT_W'(1);
    end
    fc_nxt = fc_r;
    if (acc) begin
      if (in_mode || !acc_mode_r) begin
        fc_nxt = CNT_W'(1);
      end else if (!drop && in_frame_end) begin
        fc_nxt = fc_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= CNT_W'(1);
      acc_mode_r <= ACC_MODE_RESET;
      sample_limit_r <= SAMPLE_LIMIT_RESET;
    end else begin
      fc_r <= fc_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ACC_MODE:     acc_mode_r <= cfg_data[0];
          REG_SAMPLE_LIMIT: sample_limit_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign light[0] = in_light_red;
  assign light[1] = in_light_green;
  assign light[2] = in_light_blue;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    assign lane_in[g].vld = emit;
    assign lane_in[g].addr = ADDR_W'(in_pixel_index);
    assign lane_in[g].light = light[g];
    assign lane_in[g].cnt = cnt_use;

    satm_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .lane_in  (lane_in[g]),
      .byte_out (lane_byte[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        meta_vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      meta_vld_r[0] <= emit;
      for (int i = 1; i < LANE_LAT; i++) begin
        meta_vld_r[i] <= meta_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_idx_r[0] <= in_pixel_index;
      meta_last_r[0] <= in_frame_end;
      for (int i = 1; i < LANE_LAT; i++) begin
        meta_idx_r[i] <= meta_idx_r[i-1];
        meta_last_r[i] <= meta_last_r[i-1];
      end
    end
  end

  always_comb begin
    res.idx = meta_idx_r[LANE_LAT-1];
    res.red = lane_byte[0];
    res.green = lane_byte[1];
    res.blue = lane_byte[2];
    res.last = meta_last_r[LANE_LAT-1];
  end

  satm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (meta_vld_r[LANE_LAT-1]),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign out_index = out_word.idx;
  assign out_red = out_word.red;
  assign out_green = out_word.green;
  assign out_blue = out_word.blue;
  assign out_last_pixel = out_word.last;

`ifndef SYNTHESIS
  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_mode |=> fc_r == CNT_W'(1))
    else $error("restart did not reset the frame count");
  a_display_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_mode && !acc_mode_r |=> fc_r == CNT_W'(1))
    else $error("frame count moved in display mode");
  a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_mode && drop |=> $stable(fc_r))
    else $error("dropped word changed the frame count");
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r != '0)
    else $error("frame count reached zero");
`endif

endmodule

// File: test/testbench.sv
module testbench;
  import satm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    bit              mode;
    bit [IDX_W-1:0]   idx;
    bit [LIGHT_W-1:0] light [LANES];
    bit              fe;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [IDX_W-1:0] in_pixel_index = '0;
  logic [LIGHT_W-1:0] in_light_red = '0;
  logic [LIGHT_W-1:0] in_light_green = '0;
  logic [LIGHT_W-1:0] in_light_blue = '0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_index;
  logic [BYTE_W-1:0] out_red;
  logic [BYTE_W-1:0] out_green;
  logic [BYTE_W-1:0] out_blue;
  logic out_last_pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;

  pixel_word_t pending_words [$];
  result_t expected_pixels [$];

  logic [SUM_W-1:0] sum_store [int];
  bit touched [int];
  int touched_list [$];
  bit [CNT_W-1:0] frame_cnt = 1;
  bit acc_mode = ACC_MODE_RESET;
  bit [CNT_W-1:0] smp_limit = SAMPLE_LIMIT_RESET;

  bit quiet = 0;
  bit hold_req = 0;
  int gap_left = 0;
  int stall_left = 0;
  int cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int pixels_seen = 0;
  int words_dropped = 0;
  int restarts = 0;
  int settings_used = 0;

  sample_accumulate_tonemap_unit u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] tone_byte(logic [SUM_W-1:0] s, bit [CNT_W-1:0] cnt);
    longint unsigned a, num, den, r, f, target, t;
    int k;
    if (cnt == 0) cnt = 1;
    a = s / cnt;
    if (a > 64'hFF_FFFF) a = 64'hFF_FFFF;
    num = 3 * a * (753 * a + 15 * 65536);
    den = 3 * a * (729 * a + 295 * 65536) + 64'd350 * 65536 * 65536;
    if (num >= den) return 8'hFF;
    r = num;
    f = 0;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= den) begin
        r = r - den;
        f = f | 1;
      end
    end
    target = 65025 * f;
    k = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = k | b;
      if (((t * t) << 32) <= target) k = int'(t);
    end
    return k[BYTE_W-1:0];
  endfunction

  function automatic bit [CNT_W-1:0] limit_in_force();
    return (smp_limit > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : smp_limit;
  endfunction

  task automatic predict_pixel(input pixel_word_t w);
    result_t r;
    bit [CNT_W-1:0] cnt;
    logic [SUM_W:0] s;
    logic [SUM_W-1:0] base;
    int slot;
    if (w.mode) begin
      frame_cnt = 1;
      restarts++;
      return;
    end
    if (!acc_mode) begin
      frame_cnt = 1;
    end else if (frame_cnt >= limit_in_force()) begin
      words_dropped++;
      return;
    end
    cnt = frame_cnt;
    r.idx = w.idx;
    for (int c = 0; c < LANES; c++) begin
      slot = int'(w.idx) * LANES + c;
      base = (cnt == 1 || !sum_store.exists(slot)) ? '0 : sum_store[slot];
      s = base + w.light[c];
      if (s[SUM_W]) s = {1'b0, {SUM_W{1'b1}}};
      sum_store[slot] = s[SUM_W-1:0];
      if (c == 0) r.red = tone_byte(s[SUM_W-1:0], cnt);
      else if (c == 1) r.green = tone_byte(s[SUM_W-1:0], cnt);
      else r.blue = tone_byte(s[SUM_W-1:0], cnt);
    end
    r.last = w.fe;
    expected_pixels.push_back(r);
    if (!touched.exists(w.idx)) begin
      touched[w.idx] = 1;
      touched_list.push_back(w.idx);
    end
    if (acc_mode && w.fe) frame_cnt = frame_cnt + 1;
  endtask

  task automatic send_word(input pixel_word_t w);
    bit reads_store;
    reads_store = acc_mode && frame_cnt > 1 && frame_cnt < limit_in_force();
    if (!w.mode && reads_store && !touched.exists(w.idx)) begin
      if (touched_list.size() > 0)
        w.idx = IDX_W'(touched_list[$urandom_range(0, touched_list.size() - 1)]);
      else
        w.mode = 1;
    end
    predict_pixel(w);
    pending_words.push_back(w);
  endtask

  task automatic send_pixel(input int idx, input int lr, input int lg, input int lb,
                            input bit fe);
    pixel_word_t w;
    w.mode = 0;
    w.idx = IDX_W'(idx);
    w.light[0] = LIGHT_W'(lr);
    w.light[1] = LIGHT_W'(lg);
    w.light[2] = LIGHT_W'(lb);
    w.fe = fe;
    send_word(w);
  endtask

  task automatic send_restart();
    pixel_word_t w;
    w.mode = 1;
    w.idx = IDX_W'($urandom);
    w.fe = 1'($urandom);
    for (int c = 0; c < LANES; c++) w.light[c] = LIGHT_W'($urandom);
    send_word(w);
  endtask

  function automatic bit [LIGHT_W-1:0] rand_light();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return LIGHT_W'($urandom_range(0, 1 << 18));
      default: return LIGHT_W'($urandom);
    endcase
  endfunction

  task automatic wait_drain();
    forever begin
      @(negedge clk);
      if (pending_words.size() == 0 && !in_valid && expected_pixels.size() == 0) break;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CNT_W'(data);
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input bit mode_val, input int limit_val);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_ACC_MODE, int'(mode_val));
    write_reg(REG_SAMPLE_LIMIT, limit_val);
    acc_mode = mode_val;
    smp_limit = CNT_W'(limit_val);
    settings_used++;
  endtask

  task automatic random_stream(input int n_words);
    int pool [6];
    int sent;
    int fsize;
    for (int i = 0; i < 6; i++) pool[i] = $urandom_range(0, 65535);
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(0, 99)) inside
        [0:5]: begin
          send_restart();
          sent++;
        end
        [6:13]: begin
          send_pixel($urandom_range(0, 65535), rand_light(), rand_light(), rand_light(),
                     1'($urandom));
          sent++;
        end
        default: begin
          fsize = $urandom_range(1, 6);
          for (int i = 0; i < fsize; i++) begin
            send_pixel(pool[i], rand_light(), rand_light(), rand_light(),
                       (i == fsize - 1) && ($urandom_range(0, 9) != 0));
            sent++;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    pixel_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) words_sent++;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_mode <= w.mode;
        in_pixel_index <= w.idx;
        in_light_red <= w.light[0];
        in_light_green <= w.light[1];
        in_light_blue <= w.light[2];
        in_frame_end <= w.fe;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel word at index %0d", out_index);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        check_field("out_index", e.idx, out_index);
        check_field("red", e.red, out_red);
        check_field("green", e.green, out_green);
        check_field("blue", e.blue, out_blue);
        check_field("last_pixel", e.last, out_last_pixel);
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      stall_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    configure(1, 64);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    send_restart();
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(65535, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
    send_pixel(0, 24'h010000, 24'h008000, 24'h000001, 0);
    send_pixel(65535, 24'hFFFFFF, 0, 24'h123456, 1);
    send_pixel(0, 24'h7FFFFF, 24'h800000, 24'h555555, 1);
    send_restart();
    send_pixel(0, 24'hAAAAAA, 24'h000100, 24'h0000FF, 1);

    configure(0, 64);
    send_pixel(7, 24'hFFFFFF, 24'h040000, 24'h000010, 1);
    send_pixel(7, 0, 24'h020000, 24'hFFFFFF, 1);
    send_pixel(7, 24'h001000, 24'h00C000, 24'h018000, 0);

    configure(1, 1);
    send_pixel(9, 24'h010000, 24'h010000, 24'h010000, 1);
    send_restart();
    send_pixel(9, 24'h020000, 24'h020000, 24'h020000, 0);

    configure(1, 0);
    send_pixel(11, 24'h030000, 24'h030000, 24'h030000, 1);
    send_pixel(11, 24'h040000, 24'h040000, 24'h040000, 0);

    configure(1, 64);
    hold_req = 1;
    random_stream(130);
    wait_drain();
    random_stream(120);

    configure(1, 3);
    random_stream(120);
    configure(0, 8191);
    random_stream(120);
    configure(1, 8191);
    random_stream(150);
    configure(1, 2);
    random_stream(80);

    configure(1, 4096);
    quiet = 1;
    random_stream(130);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d words over %0d register settings: %0d pixels checked,",
             words_sent, settings_used, pixels_seen);
    $display("%0d samples dropped at the limit, %0d restarts.", words_dropped, restarts);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
